// ----- sv/spq_pkg.sv -----
// Shared types and codes for the sorted priority queue.
package spq_pkg;

    localparam int ItemW  = 16;
    localparam int PrioW  = 32;
    localparam int CountW = 5;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        func_t             func;
        logic [ItemW-1:0]  new_item;
        logic [PrioW-1:0]  new_priority;
    } req_t;

    typedef struct packed {
        logic [ItemW-1:0]  out_item;
        logic [PrioW-1:0]  out_priority;
        logic              now_empty;
        logic [CountW-1:0] entry_count;
        status_t           status;
    } rsp_t;

    // What one cell shows its neighbors.
    typedef struct packed {
        logic             valid;
        logic             keep;
        logic [ItemW-1:0] item;
        logic [PrioW-1:0] prio;
    } cell_t;

    // Broadcast command to every cell.
    typedef struct packed {
        logic             shift_in;
        logic             shift_out;
        logic [ItemW-1:0] item;
        logic [PrioW-1:0] prio;
    } cmd_t;

endpackage

// ----- sv/spq_cell.sv -----
// One storage cell of the sorted queue chain.
module spq_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  spq_pkg::cmd_t cmd,
    input  spq_pkg::cell_t prev,
    input  spq_pkg::cell_t next,
    output spq_pkg::cell_t own
);
    import spq_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [ItemW-1:0] item_reg;
    logic [ItemW-1:0] item_next;
    logic [PrioW-1:0] prio_reg;
    logic [PrioW-1:0] prio_next;
    logic             keep;

    // Entries ahead of the insertion point have a strictly lower priority.
    assign keep = valid_reg && (prio_reg < cmd.prio);

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        prio_next  = prio_reg;
        if (cmd.shift_in)
        begin
            valid_next = valid_reg | prev.valid;
            if (!keep)
            begin
                if (prev.keep)
                begin
                    item_next = cmd.item;
                    prio_next = cmd.prio;
                end
                else
                begin
                    item_next = prev.item;
                    prio_next = prev.prio;
                end
            end
        end
        else if (cmd.shift_out)
        begin
            valid_next = next.valid;
            item_next  = next.item;
            prio_next  = next.prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        prio_reg <= prio_next;
    end

    assign own.valid = valid_reg;
    assign own.keep  = keep;
    assign own.item  = item_reg;
    assign own.prio  = prio_reg;

endmodule

// ----- sv/sorted_priority_queue_core.sv -----
// A result appears in the cycle after its item is accepted.
// Throughput: one item per cycle unless a held result stalls the input; every cell
// compares against the new priority in parallel and the whole chain shifts in that one cycle.
// A stalled result holds in the output register while the next item waits.
// Reset clears the cell valid bits, the entry count and the output valid;
// stored items and priorities are not reset.
module sorted_priority_queue_core #(
    parameter int DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  spq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output spq_pkg::rsp_t rsp
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    cell_t            cells [DEPTH];
    cell_t            edge_prev;
    cell_t            edge_next;
    cmd_t             cmd;
    logic [DEPTH-1:0] valid_vec;

    logic             accept;
    logic             full;
    logic             empty;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [31:0]      count_wide;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign full      = cells[DEPTH-1].valid;
    assign empty     = !cells[0].valid;

    assign cmd.shift_in  = accept && (req.func == FUNC_INSERT) && !full;
    assign cmd.shift_out = accept && (req.func == FUNC_REMOVE) && !empty;
    assign cmd.item      = req.new_item;
    assign cmd.prio      = req.new_priority;

    // The head cell sees a virtual predecessor that always stays in front.
    assign edge_prev.valid = 1'b1;
    assign edge_prev.keep  = 1'b1;
    assign edge_prev.item  = '0;
    assign edge_prev.prio  = '0;
    assign edge_next.valid = 1'b0;
    assign edge_next.keep  = 1'b0;
    assign edge_next.item  = '0;
    assign edge_next.prio  = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_t prev_c;
        cell_t next_c;
        if (i == 0)
        begin : g_first
            assign prev_c = edge_prev;
        end
        else
        begin : g_mid_prev
            assign prev_c = cells[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign next_c = edge_next;
        end
        else
        begin : g_mid_next
            assign next_c = cells[i+1];
        end
        spq_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .prev  (prev_c),
            .next  (next_c),
            .own   (cells[i])
        );
        assign valid_vec[i] = cells[i].valid;
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.shift_in)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.shift_out)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign count_wide = 32'(count_next);

    always_comb
    begin
        rsp_next.out_item     = '0;
        rsp_next.out_priority = '0;
        rsp_next.now_empty    = (count_next == '0);
        rsp_next.entry_count  = count_wide[CountW-1:0];
        rsp_next.status       = ST_OK;
        case (req.func)
            FUNC_INSERT:
            begin
                if (full)
                begin
                    rsp_next.status = ST_FULL;
                end
            end
            FUNC_REMOVE:
            begin
                if (empty)
                begin
                    rsp_next.status = ST_EMPTY;
                end
                else
                begin
                    rsp_next.out_item     = cells[0].item;
                    rsp_next.out_priority = cells[0].prio;
                end
            end
            default:
            begin
                rsp_next.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The count always equals the number of occupied cells.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == 32'(count_reg))
        else $error("entry count does not match occupied cells");

    // Occupied cells form an unbroken run from the head.
    a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec + DEPTH'(1)) & valid_vec) == '0)
        else $error("occupied cells are not contiguous from the head");

    // An accepted insert into a non-full queue grows the queue by one.
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.func == FUNC_INSERT && !full)
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not add an entry");

    // Every accepted item yields a result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid)
        else $error("accepted item produced no result");

endmodule

// ----- tb/sorted_priority_queue_core_tb.sv -----
// Self-checking testbench for the sorted priority queue core: directed table plus random traffic.
module sorted_priority_queue_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int QDEPTH     = 16;
    localparam int RAND_ITEMS = 900;
    localparam int CALM_FROM  = 750;

    logic clk;
    logic rst_n      = 1'b0;
    logic req_valid  = 1'b0;
    logic req_stall;
    req_t req        = '0;
    logic rsp_valid;
    logic rsp_stall  = 1'b0;
    rsp_t rsp;

    sorted_priority_queue_core #(
        .DEPTH(QDEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    typedef struct {
        req_t cmd;
        int   reps;
        bit   known;
        rsp_t golden;
    } step_row_t;

    step_row_t       script[$];
    rsp_t            pending_rsps[$];
    int              mismatch_count = 0;
    bit              idle_on = 1'b1;
    int              stall_left = 0;

    // Shadow copy of the queue contents, head at index 0.
    logic [ItemW-1:0] shadow_items [QDEPTH];
    logic [PrioW-1:0] shadow_prios [QDEPTH];
    int               shadow_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    function automatic rsp_t queue_step(input req_t r);
        rsp_t res;
        int   pos;
        int   k;
        res = '0;
        if (r.func == FUNC_INSERT)
        begin
            if (shadow_count >= QDEPTH)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                pos = 0;
                while (pos < shadow_count && shadow_prios[pos] < r.new_priority)
                    pos++;
                for (k = shadow_count; k > pos; k--)
                begin
                    shadow_items[k] = shadow_items[k-1];
                    shadow_prios[k] = shadow_prios[k-1];
                end
                shadow_items[pos] = r.new_item;
                shadow_prios[pos] = r.new_priority;
                shadow_count++;
                res.status = ST_OK;
            end
        end
        else
        begin
            if (shadow_count == 0)
            begin
                res.status = ST_EMPTY;
            end
            else
            begin
                res.out_item     = shadow_items[0];
                res.out_priority = shadow_prios[0];
                for (k = 1; k < shadow_count; k++)
                begin
                    shadow_items[k-1] = shadow_items[k];
                    shadow_prios[k-1] = shadow_prios[k];
                end
                shadow_count--;
                res.status = ST_OK;
            end
        end
        res.now_empty   = (shadow_count == 0);
        res.entry_count = CountW'(shadow_count);
        return res;
    endfunction

    function automatic void add_row(input func_t f, input logic [ItemW-1:0] item,
                                    input logic [PrioW-1:0] prio, input int reps,
                                    input bit known = 1'b0,
                                    input logic [ItemW-1:0] g_item = '0,
                                    input logic [PrioW-1:0] g_prio = '0,
                                    input logic g_empty = 1'b0,
                                    input int g_count = 0,
                                    input status_t g_status = ST_OK);
        step_row_t row;
        row.cmd.func                = f;
        row.cmd.new_item            = item;
        row.cmd.new_priority        = prio;
        row.reps                    = reps;
        row.known                   = known;
        row.golden.out_item         = g_item;
        row.golden.out_priority     = g_prio;
        row.golden.now_empty        = g_empty;
        row.golden.entry_count      = CountW'(g_count);
        row.golden.status           = g_status;
        script.push_back(row);
    endfunction

    function automatic req_t random_req(input int insert_pct);
        req_t r;
        r.func     = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
        r.new_item = ItemW'($urandom);
        case ($urandom_range(0, 5))
            0:       r.new_priority = '0;
            1:       r.new_priority = '1;
            2, 3:    r.new_priority = PrioW'($urandom_range(0, 7));
            default: r.new_priority = $urandom;
        endcase
        return r;
    endfunction

    // Offers one item, waits for it to be taken, then queues what it should produce.
    task automatic send_item(input req_t r, input bit known, input rsp_t golden);
        rsp_t predicted;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (req_stall);
        predicted = queue_step(r);
        pending_rsps.push_back(known ? golden : predicted);
    endtask

    // Result side: check every accepted result, then pick the next stall value.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsps.size() == 0)
            begin
                report_mismatch("result arrived with nothing expected");
            end
            else
            begin
                want = pending_rsps.pop_front();
                if (rsp.out_item != want.out_item)
                    report_mismatch($sformatf("out_item %h, expected %h",
                                              rsp.out_item, want.out_item));
                if (rsp.out_priority != want.out_priority)
                    report_mismatch($sformatf("out_priority %h, expected %h",
                                              rsp.out_priority, want.out_priority));
                if (rsp.now_empty != want.now_empty)
                    report_mismatch($sformatf("now_empty %b, expected %b",
                                              rsp.now_empty, want.now_empty));
                if (rsp.entry_count != want.entry_count)
                    report_mismatch($sformatf("entry_count %0d, expected %0d",
                                              rsp.entry_count, want.entry_count));
                if (rsp.status != want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              rsp.status, want.status));
            end
        end
        if (!idle_on)
        begin
            stall_left = 0;
            rsp_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_stall <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 13);
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    initial
    begin
        req_t cmd;
        int   insert_pct;
        int   i;
        int   k;

        // Empty queue, both priority extremes, then a remove on empty again.
        add_row(FUNC_REMOVE, 16'h0000, 32'h0000_0000, 1, 1'b1, '0, '0, 1'b1, 0, ST_EMPTY);
        add_row(FUNC_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 1, 1'b1, '0, '0, 1'b0, 1, ST_OK);
        add_row(FUNC_INSERT, 16'h0000, 32'h0000_0000, 1, 1'b1, '0, '0, 1'b0, 2, ST_OK);
        add_row(FUNC_REMOVE, 16'hFFFF, 32'hFFFF_FFFF, 1, 1'b1,
                16'h0000, 32'h0000_0000, 1'b0, 1, ST_OK);
        add_row(FUNC_REMOVE, 16'h0000, 32'h0000_0000, 1, 1'b1,
                16'hFFFF, 32'hFFFF_FFFF, 1'b1, 0, ST_OK);
        add_row(FUNC_REMOVE, 16'hFFFF, 32'hFFFF_FFFF, 1, 1'b1, '0, '0, 1'b1, 0, ST_EMPTY);
        // Equal priorities: the newest of these must come out first.
        add_row(FUNC_INSERT, 16'h0001, 32'd5, 1);
        add_row(FUNC_INSERT, 16'h0002, 32'd5, 1);
        add_row(FUNC_INSERT, 16'h0003, 32'd5, 1);
        // Fill to the brim, then one insert that must be dropped.
        add_row(FUNC_INSERT, 16'h0100, 32'd100, QDEPTH - 3);
        add_row(FUNC_INSERT, 16'hA5A5, 32'd1, 1, 1'b1, '0, '0, 1'b0, QDEPTH, ST_FULL);
        add_row(FUNC_REMOVE, 16'h0000, 32'h0000_0000, 1);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[r])
        begin
            for (k = 0; k < script[r].reps; k++)
            begin
                cmd = script[r].cmd;
                cmd.new_item     = cmd.new_item + ItemW'(k);
                cmd.new_priority = cmd.new_priority + PrioW'(k);
                send_item(cmd, script[r].known, script[r].golden);
            end
        end

        // Alternate filling, draining and balanced stretches so the queue
        // keeps hitting both the full and the empty boundary.
        insert_pct = 50;
        for (i = 0; i < RAND_ITEMS; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       insert_pct = 85;
                    1:       insert_pct = 15;
                    2:       insert_pct = 65;
                    default: insert_pct = 50;
                endcase
            end
            if (i == CALM_FROM)
                idle_on = 1'b0;
            send_item(random_req(insert_pct), 1'b0, '0);
        end
        req_valid <= 1'b0;

        while (pending_rsps.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
